// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define PQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen.
`define PQS_ASSERT_NEVER(lbl, expr, msg) \
  `PQS_ASSERT(lbl, !(expr), msg)

`endif

// ===== design/pqs_pkg.sv =====
package pqs_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } pqs_func_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_QUANTUM    = 1'b0,
    CFG_TASK_COUNT = 1'b1
  } pqs_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } pqs_state_e;

  typedef struct packed {
    pqs_func_e   func;
    logic [3:0]  entry_index;
    logic [7:0]  task_name;
    logic [15:0] arrival;
    logic [15:0] work;
    logic [7:0]  prio;
  } pqs_in_t;

  typedef struct packed {
    logic [3:0]  chosen_index;
    logic [7:0]  chosen_name;
    logic [31:0] slice_start;
    logic [15:0] slice_length;
    logic        idle;
    logic        finished;
    logic        all_done;
  } pqs_out_t;

  typedef struct packed {
    logic [7:0]  name;
    logic [15:0] arrival;
    logic [15:0] work;
    logic [7:0]  prio;
  } pqs_entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic commit;
  } pqs_cmd_t;

  typedef struct packed {
    logic scan_end;
  } pqs_status_t;

endpackage

// ===== design/pqs_dp.sv =====
`include "assert_macros.svh"

module pqs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pqs_pkg::pqs_cmd_t             cmd_i,
  output pqs_pkg::pqs_status_t          status_o,
  input  pqs_pkg::pqs_in_t              in_data_i,
  input  logic                          cfg_we_i,
  input  logic [pqs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [pqs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output pqs_pkg::pqs_out_t             out_data_o
);
  import pqs_pkg::*;

  logic [15:0]      quantum_q;
  logic [4:0]       task_count_q;
  logic [31:0]      now_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] n_used;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  pqs_entry_t       rd_q;
  logic             have_q;
  logic             any_q;
  pqs_entry_t       best_q;
  logic [IDX_W-1:0] best_idx_q;
  pqs_out_t         out_q;
  pqs_out_t         out_d;

  pqs_entry_t       mem_q [MAX_TASKS];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pqs_entry_t       wr_data;
  logic             load_ok;

  logic             cand_ready;
  logic             take;
  logic [15:0]      q_eff;
  logic [15:0]      run;
  logic [15:0]      new_work;
  logic [15:0]      adv;
  logic [32:0]      sum;
  logic [31:0]      now_next;

  always_comb begin
    if (32'(task_count_q) > 32'(MAX_TASKS)) begin
      n_used = CNT_W'(MAX_TASKS);
    end else begin
      n_used = CNT_W'(task_count_q);
    end
  end

  assign status_o.scan_end = (idx_q == n_used);

  // candidate compare
  assign cand_ready = (rd_q.work != 16'd0) && ({16'd0, rd_q.arrival} <= now_q);
  assign take = cand_ready &&
                (!have_q || (rd_q.prio > best_q.prio) ||
                 ((rd_q.prio == best_q.prio) && (rd_q.arrival < best_q.arrival)));

  // slice arithmetic
  assign q_eff    = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
  assign run      = (best_q.work < q_eff) ? best_q.work : q_eff;
  assign new_work = best_q.work - run;
  assign adv      = have_q ? run : q_eff;
  assign sum      = {1'b0, now_q} + {17'd0, adv};
  assign now_next = sum[32] ? '1 : sum[31:0];

  always_comb begin
    out_d = '0;
    if (!any_q) begin
      out_d.all_done = 1'b1;
    end else begin
      out_d.slice_start = now_q;
      if (have_q) begin
        out_d.chosen_index = 4'(best_idx_q);
        out_d.chosen_name  = best_q.name;
        out_d.slice_length = run;
        out_d.finished     = (new_work == 16'd0);
      end else begin
        out_d.slice_length = q_eff;
        out_d.idle         = 1'b1;
      end
    end
  end

  // table write port: load or work update
  assign load_ok = (32'(in_data_i.entry_index) < 32'(MAX_TASKS));
  assign wr_en   = (cmd_i.load && load_ok) || (cmd_i.commit && any_q && have_q);

  always_comb begin
    if (cmd_i.load) begin
      wr_addr = IDX_W'(in_data_i.entry_index);
      wr_data = {in_data_i.task_name, in_data_i.arrival, in_data_i.work, in_data_i.prio};
    end else begin
      wr_addr = best_idx_q;
      wr_data = {best_q.name, best_q.arrival, new_work, best_q.prio};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.issue) begin
      rd_q     <= mem_q[idx_q[IDX_W-1:0]];
      rd_idx_q <= idx_q[IDX_W-1:0];
    end
    if (rd_vld_q && take) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q    <= 16'd2;
      task_count_q <= '0;
      now_q        <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      have_q       <= 1'b0;
      any_q        <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_QUANTUM:    quantum_q    <= cfg_wdata_i;
          CFG_TASK_COUNT: task_count_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        idx_q  <= '0;
        have_q <= 1'b0;
        any_q  <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (rd_q.work != 16'd0) begin
            any_q <= 1'b1;
          end
          if (take) begin
            have_q <= 1'b1;
          end
        end
      end
      if (cmd_i.load) begin
        now_q <= '0;
      end else if (cmd_i.commit) begin
        out_q <= out_d;
        if (any_q) begin
          now_q <= now_next;
        end
      end
    end
  end

  assign out_data_o = out_q;

  `PQS_ASSERT(a_load_clears_now, cmd_i.load |=> (now_q == '0), "load did not clear clock")
  `PQS_ASSERT(a_done_keeps_now, (cmd_i.commit && !any_q) |=> $stable(now_q),
              "clock moved on all-done")
  `PQS_ASSERT_NEVER(a_commit_undrained, cmd_i.commit && rd_vld_q,
                    "commit with a scan read still pending")
  `PQS_ASSERT(a_flags_excl, $onehot0({out_q.idle, out_q.finished, out_q.all_done}),
              "result flags overlap")

endmodule

// ===== design/pqs_ctrl.sv =====
`include "assert_macros.svh"

module pqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  pqs_pkg::pqs_func_e   in_func_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  pqs_pkg::pqs_status_t status_i,
  output pqs_pkg::pqs_cmd_t    cmd_o
);
  import pqs_pkg::*;

  pqs_state_e state_q;
  pqs_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_func_i == FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `PQS_ASSERT(a_out_to_idle, (state_q == ST_OUT && !out_stall_i) |=> (state_q == ST_IDLE),
              "result beat taken but controller not idle")
  `PQS_ASSERT(a_cmd_excl, $onehot0({cmd_o.load, cmd_o.start, cmd_o.issue, cmd_o.commit}),
              "overlapping datapath commands")

endmodule

// ===== design/priority_quantum_scheduler_top.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o    pqs_in_t (load or step beat)
// out      output     out_valid_o/out_stall_i  pqs_out_t (one beat per step)
// cfg      input      cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// A load beat leaves the controller idle; the next beat is accepted in the following cycle.
// A step beat scans the first min(task_count,16) table entries in turn through the
// single table read port, registers each read and compares it, then updates the
// chosen entry and registers the result. The next beat is taken once the result leaves.
// rst_ni clears control, clock and count at once, sets quantum to 2; table not cleared.
// A stalled result holds in the output register; input stays stalled meanwhile.
module priority_quantum_scheduler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pqs_pkg::pqs_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pqs_pkg::pqs_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pqs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [pqs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pqs_pkg::*;

  pqs_cmd_t    cmd;
  pqs_status_t status;

  pqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pqs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule
